// ----- rtl/level_file_bound_indexer_unit_defines.svh -----
// Assertion helpers for the bound indexer.
`ifndef LEVEL_FILE_BOUND_INDEXER_UNIT_DEFINES_SVH
`define LEVEL_FILE_BOUND_INDEXER_UNIT_DEFINES_SVH

`define LFBI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define LFBI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/lfbi_pkg.sv -----
`timescale 1ns / 1ps
package lfbi_pkg;
    localparam int MaxLevels = 8;
    localparam int MaxFiles  = 64;
    localparam int KeyBits   = 64;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_COUNT  = 2'd1;
    localparam logic [1:0] OP_BUILD  = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    localparam logic [1:0] F_SM_LB = 2'd0;
    localparam logic [1:0] F_LG_LB = 2'd1;
    localparam logic [1:0] F_SM_RB = 2'd2;
    localparam logic [1:0] F_LG_RB = 2'd3;

    localparam logic [1:0] REG_LEVELS_ADDR  = 2'd0;
    localparam logic [3:0] REG_LEVELS_RESET = 4'd7;

    // Result of one key comparison inside the walker.
    typedef struct packed {
        logic lt;
        logic gt;
    } t_cmp;
endpackage

// ----- rtl/level_file_bound_indexer_unit.sv -----
`timescale 1ns / 1ps
// Write, count, rejected and last-level lookup words go from S_EXEC straight to S_DONE;
// a full lookup first reads its bound table entry in S_LK_RD, S_LK_WAIT and S_LK_OUT.
// o_valid is registered from S_DONE, and a new word is accepted in the strobe cycle.
// A build walks each level pair from level 1 on four times through S_W_RD, S_W_WAIT,
// S_W_STEP or S_W_TAIL, and S_W_WR. busy is high from acceptance until the result strobe.
// Synchronous reset clears counts, built sizes and control; key and bound memories are not.
`include "level_file_bound_indexer_unit_defines.svh"
module level_file_bound_indexer_unit #(
    parameter int MAX_LEVELS = lfbi_pkg::MaxLevels,
    parameter int MAX_FILES  = lfbi_pkg::MaxFiles,
    parameter int KEY_BITS   = lfbi_pkg::KeyBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_level,
    input  logic [5:0]  i_file_index,
    input  logic [6:0]  i_file_count,
    input  logic [63:0] i_smallest_key,
    input  logic [63:0] i_largest_key,
    input  logic signed [1:0] i_cmp_low,
    input  logic signed [1:0] i_cmp_high,
    output logic        o_valid,
    output logic [6:0]  o_left_bound,
    output logic signed [6:0] o_right_bound,
    output logic        o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int LW = $clog2(MAX_LEVELS);
    localparam int SLOTS = MAX_LEVELS * MAX_FILES;
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(MAX_FILES + 1) + 1;   // signed count/index
    localparam int BW = 4 * CW;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_LK_RD, S_LK_WAIT, S_LK_OUT,
        S_BLD_LV, S_BLD_WALK, S_W_RD, S_W_WAIT, S_W_STEP, S_W_TAIL, S_W_WR,
        S_BLD_NEXT, S_DONE
    } t_state;

    t_state r_state;
    logic [3:0] r_levels;
    logic [CW-1:0] r_lsize [MAX_LEVELS];
    logic [CW-1:0] r_bsize [MAX_LEVELS];

    logic [1:0] r_op;
    logic [2:0] r_lv;
    logic [5:0] r_fi;
    logic [6:0] r_cnt;
    logic [63:0] r_sk, r_lk;
    logic signed [1:0] r_cl, r_ch;
    logic [6:0] r_lb, r_rb;
    logic r_st;

    // Build walker state.
    logic [LW-1:0] r_blv;
    logic [1:0] r_walk;
    logic signed [CW-1:0] r_u, r_l;
    logic r_tail;
    logic signed [CW-1:0] r_wval;
    logic [BW-1:0] r_entry_hold;

    // Effective level count.
    logic [4:0] eff;
    always_comb begin
        if (r_levels < 4'd2) eff = 5'd2;
        else if ({1'b0, r_levels} > 5'(MAX_LEVELS)) eff = 5'(MAX_LEVELS);
        else eff = {1'b0, r_levels};
    end

    // Config port.
    assign pready = 1'b1;
    assign prdata = {28'd0, r_levels};
    wire cfg_wr = psel && penable && pwrite && pready;

    // Key memories.
    logic key_we;
    logic wr_bad;
    logic [AW-1:0] key_waddr, key_raddr_a, key_raddr_b;
    logic [KEY_BITS-1:0] lo_a, hi_a, lo_b, hi_b;
    assign wr_bad = ({1'b0, r_lv} >= 4'(MAX_LEVELS)) || ({1'b0, r_fi} >= 7'(MAX_FILES));
    assign key_we = (r_state == S_EXEC) && (r_op == lfbi_pkg::OP_WRITE) && !wr_bad;
    assign key_waddr = AW'(r_lv) * AW'(MAX_FILES) + AW'(r_fi);

    lfbi_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_lo_a (.i_clk(i_clk), .i_we(key_we),
        .i_waddr(key_waddr), .i_wdata(r_sk[KEY_BITS-1:0]), .i_raddr(key_raddr_a),
        .o_rdata(lo_a));
    lfbi_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_hi_a (.i_clk(i_clk), .i_we(key_we),
        .i_waddr(key_waddr), .i_wdata(r_lk[KEY_BITS-1:0]), .i_raddr(key_raddr_a),
        .o_rdata(hi_a));
    lfbi_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_lo_b (.i_clk(i_clk), .i_we(key_we),
        .i_waddr(key_waddr), .i_wdata(r_sk[KEY_BITS-1:0]), .i_raddr(key_raddr_b),
        .o_rdata(lo_b));
    lfbi_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_hi_b (.i_clk(i_clk), .i_we(key_we),
        .i_waddr(key_waddr), .i_wdata(r_lk[KEY_BITS-1:0]), .i_raddr(key_raddr_b),
        .o_rdata(hi_b));

    assign key_raddr_a = AW'(r_blv) * AW'(MAX_FILES) + AW'(r_u[CW-2:0]);
    assign key_raddr_b = (AW'(r_blv) + AW'(1)) * AW'(MAX_FILES) + AW'(r_l[CW-2:0]);

    // Walk 0: upper low vs lower high, left. 1: upper high vs lower high, left.
    // 2: upper low vs lower low, right. 3: upper high vs lower low, right.
    logic [KEY_BITS-1:0] ka, kb;
    assign ka = r_walk[0] ? hi_a : lo_a;
    assign kb = r_walk[1] ? lo_b : hi_b;
    lfbi_pkg::t_cmp cmp;
    lfbi_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (.i_a(ka), .i_b(kb), .o_cmp(cmp));

    // Bound table: read-modify-write of one entry per put.
    logic bt_we;
    logic [AW-1:0] bt_waddr, bt_raddr;
    logic [BW-1:0] bt_wdata, bt_rdata;
    lfbi_ram #(.WIDTH(BW), .DEPTH(SLOTS)) u_bt (.i_clk(i_clk), .i_we(bt_we),
        .i_waddr(bt_waddr), .i_wdata(bt_wdata), .i_raddr(bt_raddr), .o_rdata(bt_rdata));
    assign bt_waddr = AW'(r_blv) * AW'(MAX_FILES) + AW'(r_u[CW-2:0]);

    logic lk_prev;
    always_comb begin
        bt_wdata = r_entry_hold;
        bt_wdata[r_walk*CW +: CW] = r_wval;
        bt_we = (r_state == S_W_WR);
    end
    logic [5:0] lk_file;
    assign lk_prev = (r_cl < 0);
    assign lk_file = (r_state == S_LK_RD && lk_prev) ? r_fi - 6'd1 : r_fi;
    always_comb begin
        if (r_state == S_LK_RD || r_state == S_LK_WAIT)
            bt_raddr = AW'(r_lv) * AW'(MAX_FILES) + AW'(lk_file);
        else
            bt_raddr = bt_waddr;
    end

    logic signed [CW-1:0] usz, lsz;
    assign usz = r_lsize[r_blv];
    assign lsz = r_lsize[r_blv + LW'(1)];
    wire left_walk = !r_walk[1];
    logic signed [CW-1:0] prev_lg_lb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_levels <= lfbi_pkg::REG_LEVELS_RESET;
            o_valid <= 1'b0;
            for (int k = 0; k < MAX_LEVELS; k++) begin
                r_lsize[k] <= '0;
                r_bsize[k] <= '0;
            end
        end else begin
            o_valid <= (r_state == S_DONE);
            if (cfg_wr && paddr == lfbi_pkg::REG_LEVELS_ADDR) r_levels <= pwdata[3:0];
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op <= i_op; r_lv <= i_level; r_fi <= i_file_index;
                        r_cnt <= i_file_count; r_sk <= i_smallest_key;
                        r_lk <= i_largest_key; r_cl <= i_cmp_low; r_ch <= i_cmp_high;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_lb <= 7'd0; r_rb <= 7'h7f;
                    case (r_op)
                        lfbi_pkg::OP_WRITE: begin
                            r_st <= wr_bad;
                            r_state <= S_DONE;
                        end
                        lfbi_pkg::OP_COUNT: begin
                            if ({1'b0, r_lv} >= 4'(MAX_LEVELS) || r_cnt > 7'(MAX_FILES)) begin
                                r_st <= 1'b1;
                            end else begin
                                r_st <= 1'b0;
                                r_lsize[r_lv[LW-1:0]] <= CW'(r_cnt);
                            end
                            r_state <= S_DONE;
                        end
                        lfbi_pkg::OP_BUILD: begin
                            r_st <= 1'b0;
                            r_blv <= LW'(1);
                            r_state <= S_BLD_LV;
                        end
                        default: begin
                            if (r_lv == 3'd0 || {2'b0, r_lv} >= eff) begin
                                r_st <= 1'b1; r_state <= S_DONE;
                            end else if ({2'b0, r_lv} == eff - 5'd1) begin
                                r_st <= 1'b0; r_state <= S_DONE;
                            end else if (CW'(r_fi) >= r_bsize[r_lv[LW-1:0]]) begin
                                r_st <= 1'b1; r_state <= S_DONE;
                            end else begin
                                r_st <= 1'b0; r_state <= S_LK_RD;
                            end
                        end
                    endcase
                end
                S_LK_RD: begin
                    r_state <= S_LK_WAIT;
                end
                S_LK_WAIT: begin
                    prev_lg_lb <= (r_fi == 6'd0) ? '0 : bt_rdata[CW +: CW];
                    r_state <= S_LK_OUT;
                end
                S_LK_OUT: begin
                    if (r_cl < 0) begin
                        r_lb <= 7'(prev_lg_lb);
                        r_rb <= 7'(bt_rdata[2*CW +: CW]);
                    end else if (r_cl == 0) begin
                        r_lb <= 7'(bt_rdata[0 +: CW]);
                        r_rb <= 7'(bt_rdata[2*CW +: CW]);
                    end else if (r_ch < 0) begin
                        r_lb <= 7'(bt_rdata[0 +: CW]);
                        r_rb <= 7'(bt_rdata[3*CW +: CW]);
                    end else if (r_ch == 0) begin
                        r_lb <= 7'(bt_rdata[CW +: CW]);
                        r_rb <= 7'(bt_rdata[3*CW +: CW]);
                    end else begin
                        r_lb <= 7'(bt_rdata[CW +: CW]);
                        r_rb <= 7'(r_bsize[r_lv[LW-1:0] + LW'(1)] - CW'(1));
                    end
                    r_state <= S_DONE;
                end
                S_BLD_LV: begin
                    if (5'(r_blv) + 5'd1 >= eff) begin
                        r_bsize[eff[LW-1:0] - LW'(1)] <= r_lsize[eff[LW-1:0] - LW'(1)];
                        r_state <= S_DONE;
                    end else begin
                        r_bsize[r_blv] <= r_lsize[r_blv];
                        r_walk <= 2'd0;
                        r_state <= (r_lsize[r_blv] == '0) ? S_BLD_NEXT : S_BLD_WALK;
                    end
                end
                S_BLD_WALK: begin
                    r_tail <= 1'b0;
                    if (left_walk) begin
                        r_u <= '0; r_l <= '0;
                    end else begin
                        r_u <= usz - CW'(1); r_l <= lsz - CW'(1);
                    end
                    r_state <= S_W_RD;
                end
                S_W_RD: begin
                    if (left_walk ? (r_u >= usz) : (r_u < 0)) begin
                        r_walk <= r_walk + 2'd1;
                        r_state <= (r_walk == 2'd3) ? S_BLD_NEXT : S_BLD_WALK;
                    end else begin
                        if (left_walk ? (r_l >= lsz) : (r_l < 0)) r_tail <= 1'b1;
                        r_state <= S_W_WAIT;
                    end
                end
                S_W_WAIT: begin
                    r_state <= r_tail ? S_W_TAIL : S_W_STEP;
                end
                S_W_TAIL: begin
                    r_entry_hold <= bt_rdata;
                    r_wval <= left_walk ? lsz : '1;
                    r_state <= S_W_WR;
                end
                S_W_STEP: begin
                    r_entry_hold <= bt_rdata;
                    r_wval <= r_l;
                    if (left_walk ? cmp.gt : cmp.lt) begin
                        r_l <= left_walk ? r_l + CW'(1) : r_l - CW'(1);
                        r_state <= S_W_RD;
                    end else begin
                        r_state <= S_W_WR;
                    end
                end
                S_W_WR: begin
                    // Equal keys advance both walkers; the compare is still valid here.
                    if (!r_tail && !cmp.lt && !cmp.gt)
                        r_l <= left_walk ? r_l + CW'(1) : r_l - CW'(1);
                    r_u <= left_walk ? r_u + CW'(1) : r_u - CW'(1);
                    r_state <= S_W_RD;
                end
                S_BLD_NEXT: begin
                    r_blv <= r_blv + LW'(1);
                    r_state <= S_BLD_LV;
                end
                S_DONE: begin
                    o_left_bound <= r_st ? 7'd0 : r_lb;
                    o_right_bound <= r_st ? 7'h7f : r_rb;
                    o_status <= r_st;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);

    `LFBI_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `LFBI_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `LFBI_ASSERT_IMP(a_rej_bounds, i_clk, i_rst_n, o_valid && o_status,
        o_left_bound == 7'd0 && o_right_bound == 7'h7f)
endmodule

// ----- rtl/lfbi_ram.sv -----
`timescale 1ns / 1ps
module lfbi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/lfbi_cmp.sv -----
`timescale 1ns / 1ps
module lfbi_cmp #(
    parameter int KEY_BITS = lfbi_pkg::KeyBits
) (
    input  logic [KEY_BITS-1:0] i_a,
    input  logic [KEY_BITS-1:0] i_b,
    output lfbi_pkg::t_cmp      o_cmp
);
    assign o_cmp.lt = i_a < i_b;
    assign o_cmp.gt = i_a > i_b;
endmodule
